@@ design/tcw_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, codes and control structs for the congestion window tracker.
package tcw_pkg;

    localparam int WINDOW_BITS   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int FIX_BITS      = WINDOW_BITS + FRACTION_BITS;
    localparam int QUO_BITS      = FRACTION_BITS + 1;
    localparam int CNT_BITS      = $clog2(FRACTION_BITS + 1);
    localparam int MIN_BITS      = (WINDOW_BITS > 16) ? WINDOW_BITS : 16;

    localparam int FIELD_BITS    = 16;
    localparam int KIND_BITS     = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_BITS      = 3 * FIELD_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [WINDOW_BITS-1:0] WIN_MAX  = {WINDOW_BITS{1'b1}};
    localparam logic [FIX_BITS-1:0]    FIX_ONE  = FIX_BITS'(1) << FRACTION_BITS;
    localparam logic [FIX_BITS-1:0]    FIX_HALF = FIX_BITS'(1) << (FRACTION_BITS - 1);
    localparam logic [FIX_BITS-1:0]    FIX_MAX  = {WIN_MAX, {FRACTION_BITS{1'b0}}};

    localparam logic [WINDOW_BITS-1:0] THRESH_FLOOR = WINDOW_BITS'(2);
    localparam logic [WINDOW_BITS-1:0] THRESH_RESET = WINDOW_BITS'(128);
    localparam logic [FIELD_BITS-1:0]  LIMIT_RESET  = FIELD_BITS'(64);

    localparam logic [KIND_BITS-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DUPACK  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_SEND_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT_THRESH = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic apply;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic needs_div;
        logic div_done;
    } t_stat;

endpackage

@@ design/tcp_congestion_window.sv @@
`timescale 1ns / 1ps
// An ack in congestion avoidance passes from accept through the 1/cwnd divider, one
// quotient bit per cycle, then update and result load; other events skip the divider.
// One word at a time: the next word is accepted once the previous result is loaded;
// the result register lets a new word in while the last result still waits downstream.
// Reset (i_rst_n, synchronous, low): cwnd 1, fixed-point window 1.0, ssthresh 128, limit 64.
module tcp_congestion_window import tcw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,  // [15:0] receiver_window
    input  logic [KIND_BITS-1:0]     i_s_axis_tuser,  // [1:0] kind
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // [15:0] congestion_window, [31:16] slow_start_threshold, [47:32] send_window,
    // [48] in_slow_start, [55:49] zero
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [FIELD_BITS-1:0]    i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    tcw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_kind      (i_s_axis_tuser),
        .i_recv      (i_s_axis_tdata[FIELD_BITS-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_data      (o_m_axis_tdata)
    );

    // a result must never overwrite a word still waiting downstream
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result loaded over a pending word");

    // a loaded result is presented on the next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_m_axis_tvalid)
        else $error("emitted result not presented");

    // no new word accepted while an item is still in the divider or being applied
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.div_step || w_cmd.apply) |-> !o_s_axis_tready)
        else $error("input accepted while busy");

    // congestion window reported is never zero
    a_cwnd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[FIELD_BITS-1:0] != '0))
        else $error("zero congestion window reported");

endmodule

@@ design/tcw_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the congestion window tracker: handshakes and datapath commands.
module tcw_ctrl import tcw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    output logic  o_s_ready,
    output logic  o_m_valid,
    input  logic  i_m_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_s_valid;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.apply    = (r_state == S_UPD);
        // result register is free, or its word leaves this cycle
        o_cmd.emit     = (r_state == S_DONE) && (!r_out_valid || i_m_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = i_stat.needs_div ? S_DIV : S_UPD;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (o_cmd.emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

endmodule

@@ design/tcw_dp.sv @@
`timescale 1ns / 1ps
// Datapath: window state, threshold, 1/cwnd restoring divider and result register.
module tcw_dp import tcw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic [KIND_BITS-1:0]     i_kind,
    input  logic [FIELD_BITS-1:0]    i_recv,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [FIELD_BITS-1:0]    i_cfg_data,
    output logic [OUT_DATA_BITS-1:0] o_data
);

    logic [WINDOW_BITS-1:0]   r_whole;
    logic [FIX_BITS-1:0]      r_frac;
    logic [WINDOW_BITS-1:0]   r_thr;
    logic [FIELD_BITS-1:0]    r_limit;
    logic [KIND_BITS-1:0]     r_kind;
    logic [FIELD_BITS-1:0]    r_recv;
    logic [WINDOW_BITS-1:0]   r_rem;
    logic [QUO_BITS-1:0]      r_quo;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [OUT_DATA_BITS-1:0] r_out;

    logic                   w_ss;
    logic [WINDOW_BITS:0]   w_trial;
    logic                   w_ge;
    logic [WINDOW_BITS:0]   w_trial_sub;
    logic [FIX_BITS-1:0]    w_step;
    logic [FIX_BITS-1:0]    w_add;
    logic [FIX_BITS:0]      w_sum;
    logic [FIX_BITS-1:0]    w_frac_sat;
    logic [FIX_BITS:0]      w_round;
    logic [WINDOW_BITS-1:0] w_whole_ca;
    logic [WINDOW_BITS-1:0] w_whole_ss;
    logic [WINDOW_BITS-1:0] w_half;
    logic [WINDOW_BITS-1:0] w_thr_cong;
    logic [MIN_BITS-1:0]    w_min_a;
    logic [MIN_BITS-1:0]    w_min_b;
    logic [MIN_BITS-1:0]    w_send;

    assign w_ss = (r_whole <= r_thr);

    assign o_stat.needs_div = (i_kind == KIND_ACK) && !w_ss;
    assign o_stat.div_done  = (r_cnt == '0);

    // restoring division of 1.0 by cwnd; the dividend has a single set bit at the top
    assign w_trial     = {r_rem, (r_cnt == CNT_BITS'(FRACTION_BITS))};
    assign w_ge        = (w_trial >= {1'b0, r_whole});
    assign w_trial_sub = w_trial - {1'b0, r_whole};

    // congestion avoidance / slow start update of the fixed-point window
    assign w_step     = (r_whole == '0) ? FIX_ONE : FIX_BITS'(r_quo);
    assign w_add      = w_ss ? FIX_ONE : w_step;
    assign w_sum      = {1'b0, r_frac} + {1'b0, w_add};
    assign w_frac_sat = (w_sum > {1'b0, FIX_MAX}) ? FIX_MAX : w_sum[FIX_BITS-1:0];
    assign w_round    = {1'b0, w_frac_sat} + {1'b0, FIX_HALF};
    assign w_whole_ca = w_round[FIX_BITS-1:FRACTION_BITS];
    assign w_whole_ss = (r_whole == WIN_MAX) ? r_whole : r_whole + WINDOW_BITS'(1);

    assign w_half     = r_whole >> 1;
    assign w_thr_cong = (w_half > THRESH_FLOOR) ? w_half : THRESH_FLOOR;

    assign w_min_a = (MIN_BITS'(r_limit) < MIN_BITS'(r_recv)) ?
                     MIN_BITS'(r_limit) : MIN_BITS'(r_recv);
    assign w_min_b = MIN_BITS'(r_whole);
    assign w_send  = (w_min_a < w_min_b) ? w_min_a : w_min_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whole <= WINDOW_BITS'(1);
            r_frac  <= FIX_ONE;
            r_thr   <= THRESH_RESET;
            r_limit <= LIMIT_RESET;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= CNT_BITS'(FRACTION_BITS);
            end else if (i_cmd.div_step && (r_cnt != '0)) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
            end
            if (i_cmd.apply) begin
                case (r_kind)
                    KIND_ACK: begin
                        r_whole <= w_ss ? w_whole_ss : w_whole_ca;
                        r_frac  <= w_frac_sat;
                    end
                    KIND_TIMEOUT: begin
                        r_thr   <= w_thr_cong;
                        r_whole <= WINDOW_BITS'(1);
                        r_frac  <= FIX_ONE;
                    end
                    KIND_DUPACK: begin
                        r_thr <= w_thr_cong;
                    end
                    default: begin
                        // unused event code: state untouched
                    end
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SEND_LIMIT: begin
                        r_limit <= i_cfg_data;
                    end
                    REG_INIT_THRESH: begin
                        r_thr <= WINDOW_BITS'(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_recv <= i_recv;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_trial_sub[WINDOW_BITS-1:0] : w_trial[WINDOW_BITS-1:0];
            r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
        end
        if (i_cmd.emit) begin
            r_out <= OUT_DATA_BITS'({w_ss,
                                     FIELD_BITS'(w_send),
                                     FIELD_BITS'(r_thr),
                                     FIELD_BITS'(r_whole)});
        end
    end

    assign o_data = r_out;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the congestion window tracker: directed table, random event runs.
module tb;
    import tcw_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 300;
    localparam int RANDOM_ITEMS   = PHASE_COUNT * PHASE_ITEMS;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int TAIL_ACKS      = 40;
    localparam int DIRECTED_COUNT = 17;

    // kind 3 has no meaning to the block
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic                  slow;
        logic [FIELD_BITS-1:0] swnd;
        logic [FIELD_BITS-1:0] thr;
        logic [FIELD_BITS-1:0] cwnd;
    } t_wnd_result;

    typedef struct packed {
        logic [KIND_BITS-1:0]    kind;
        logic [IN_DATA_BITS-1:0] recv;
        logic                    pinned;
        t_wnd_result             want;
    } t_directed_row;

    // Rows with pinned set carry a result worked out by hand (reset limit 64, threshold 128).
    localparam t_directed_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{KIND_ACK,     16'hFFFF, 1'b1, '{1'b1, 16'd2, 16'd128, 16'd2}},
        '{KIND_ACK,     16'h0000, 1'b1, '{1'b1, 16'd0, 16'd128, 16'd3}},
        '{KIND_DUPACK,  16'h03E8, 1'b1, '{1'b0, 16'd3, 16'd2,   16'd3}},
        '{KIND_ACK,     16'hFFFF, 1'b0, '0},
        '{KIND_ACK,     16'h00FF, 1'b0, '0},
        '{KIND_TIMEOUT, 16'h8000, 1'b1, '{1'b1, 16'd1, 16'd2,   16'd1}},
        '{KIND_UNUSED,  16'h5555, 1'b1, '{1'b1, 16'd1, 16'd2,   16'd1}},
        '{KIND_DUPACK,  16'hAAAA, 1'b1, '{1'b1, 16'd1, 16'd2,   16'd1}},
        '{KIND_TIMEOUT, 16'h0001, 1'b1, '{1'b1, 16'd1, 16'd2,   16'd1}},
        '{KIND_ACK,     16'h0001, 1'b1, '{1'b1, 16'd1, 16'd2,   16'd2}},
        '{KIND_ACK,     16'hFF00, 1'b1, '{1'b0, 16'd3, 16'd2,   16'd3}},
        '{KIND_ACK,     16'h7FFF, 1'b0, '0},
        '{KIND_ACK,     16'h0040, 1'b0, '0},
        '{KIND_UNUSED,  16'h0000, 1'b0, '0},
        '{KIND_DUPACK,  16'hFFFF, 1'b0, '0},
        '{KIND_ACK,     16'h0003, 1'b0, '0},
        '{KIND_TIMEOUT, 16'hFFFF, 1'b0, '0}
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_axis_tvalid;
    logic                     o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]  i_s_axis_tdata;   // [15:0] receiver_window
    logic [KIND_BITS-1:0]     i_s_axis_tuser;   // [1:0] kind
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready;
    // [15:0] congestion_window, [31:16] slow_start_threshold, [47:32] send_window,
    // [48] in_slow_start
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [FIELD_BITS-1:0]    i_cfg_data;

    tcp_congestion_window dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // window model
    logic [FIELD_BITS-1:0]  limit_m;
    logic [WINDOW_BITS-1:0] cwnd_m;
    logic [WINDOW_BITS-1:0] ssthresh_m;
    logic [FIX_BITS:0]      fix_m;      // one spare bit so the add cannot wrap

    t_wnd_result pending_windows [$];
    logic        pin_valid;
    t_wnd_result pin_result;

    int mismatches;
    int words_checked;
    int kind_tally [4];
    int peak_cwnd;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int hold_served;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_wnd_result advance_window(input logic [KIND_BITS-1:0] kind,
                                                   input logic [IN_DATA_BITS-1:0] recv);
        logic [FIX_BITS:0]      rounded;
        logic [WINDOW_BITS-1:0] half;
        logic [FIELD_BITS-1:0]  send;
        t_wnd_result            r;
        case (kind)
            KIND_ACK: begin
                if (cwnd_m <= ssthresh_m) begin
                    if (cwnd_m != WIN_MAX) cwnd_m = cwnd_m + 1'b1;
                    fix_m = fix_m + FIX_ONE;
                    if (fix_m > FIX_MAX) fix_m = (FIX_BITS + 1)'(FIX_MAX);
                end else begin
                    // grow by 1/cwnd, then round the fixed-point window to nearest
                    fix_m = fix_m + (FIX_BITS + 1)'(FIX_ONE) / (FIX_BITS + 1)'(cwnd_m);
                    if (fix_m > FIX_MAX) fix_m = (FIX_BITS + 1)'(FIX_MAX);
                    rounded = (fix_m + FIX_HALF) >> FRACTION_BITS;
                    cwnd_m = (rounded > WIN_MAX) ? WIN_MAX : rounded[WINDOW_BITS-1:0];
                end
            end
            KIND_TIMEOUT, KIND_DUPACK: begin
                half = cwnd_m >> 1;
                ssthresh_m = (half > THRESH_FLOOR) ? half : THRESH_FLOOR;
                if (kind == KIND_TIMEOUT) begin
                    cwnd_m = WINDOW_BITS'(1);
                    fix_m = (FIX_BITS + 1)'(FIX_ONE);
                end
            end
            default: ;
        endcase
        send = (limit_m < recv) ? limit_m : recv;
        if (cwnd_m < send) send = cwnd_m;
        r.cwnd = cwnd_m;
        r.thr  = ssthresh_m;
        r.swnd = send;
        r.slow = (cwnd_m <= ssthresh_m);
        return r;
    endfunction

    task automatic note_field(input string name, input logic [FIELD_BITS-1:0] want,
                              input logic [FIELD_BITS-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // monitor: model tracks config writes and accepted words, results checked in order
    always @(posedge i_clk) begin
        t_wnd_result want;
        t_wnd_result got;
        if (!i_rst_n) begin
            limit_m    = LIMIT_RESET;
            ssthresh_m = THRESH_RESET;
            cwnd_m     = WINDOW_BITS'(1);
            fix_m      = (FIX_BITS + 1)'(FIX_ONE);
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SEND_LIMIT) limit_m = i_cfg_data;
                else if (i_cfg_index == REG_INIT_THRESH) ssthresh_m = i_cfg_data;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.cwnd = o_m_axis_tdata[15:0];
                got.thr  = o_m_axis_tdata[31:16];
                got.swnd = o_m_axis_tdata[47:32];
                got.slow = o_m_axis_tdata[48];
                if (pending_windows.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, got %h",
                             $time, o_m_axis_tdata);
                end else begin
                    want = pending_windows.pop_front();
                    note_field("congestion_window", want.cwnd, got.cwnd);
                    note_field("slow_start_threshold", want.thr, got.thr);
                    note_field("send_window", want.swnd, got.swnd);
                    note_field("in_slow_start", 16'(want.slow), 16'(got.slow));
                    words_checked++;
                    if (int'(want.cwnd) > peak_cwnd) peak_cwnd = int'(want.cwnd);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                want = advance_window(i_s_axis_tuser, i_s_axis_tdata);
                if (pin_valid) want = pin_result;
                pending_windows.push_back(want);
                kind_tally[i_s_axis_tuser]++;
            end
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        i_m_axis_tready = 1'b0;
        hold_served = 0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog: ends the run after too long without any handshake, config write or reset
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || i_cfg_we || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // called just after a falling edge; returns just after the falling edge past acceptance
    task automatic push_event(input logic [KIND_BITS-1:0] kind,
                              input logic [IN_DATA_BITS-1:0] recv,
                              input logic pinned, input t_wnd_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= recv;
        i_s_axis_tuser  <= kind;
        pin_valid       <= pinned;
        pin_result      <= want;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [FIELD_BITS-1:0] value);
        i_s_axis_tvalid <= 1'b0;
        while (pending_windows.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [IN_DATA_BITS-1:0] pick_recv();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return IN_DATA_BITS'($urandom_range(0, 80));
            default: return IN_DATA_BITS'($urandom);
        endcase
    endfunction

    function automatic void set_idling(input int done);
        if (done < RANDOM_ITEMS / 3) begin
            tx_idle_pct = 10;
            rx_idle_pct = 72;
        end else if (done < 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 72;
            rx_idle_pct = 10;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endfunction

    initial begin
        int                    done;
        int                    n;
        int                    run_len;
        logic [FIELD_BITS-1:0] lim;
        logic [FIELD_BITS-1:0] thr;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = KIND_ACK;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_SEND_LIMIT;
        i_cfg_data      = '0;
        pin_valid       = 1'b0;
        pin_result      = '0;
        mismatches      = 0;
        words_checked   = 0;
        peak_cwnd       = 0;
        hold_requests   = 0;
        done            = 0;
        foreach (kind_tally[k]) kind_tally[k] = 0;
        set_idling(0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            push_event(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].recv,
                       DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin lim = LIMIT_RESET; thr = THRESH_RESET; end
                1: begin lim = '0;          thr = 16'd1; end
                2: begin lim = '1;          thr = '0; end    // zero threshold: never slow start
                3: begin lim = 16'd5;       thr = 16'd3; end
                4: begin lim = FIELD_BITS'($urandom_range(1, 200));
                         thr = FIELD_BITS'($urandom_range(1, 600)); end
                default: begin lim = FIELD_BITS'($urandom); thr = FIELD_BITS'($urandom); end
            endcase
            write_reg(REG_SEND_LIMIT, lim);
            write_reg(REG_INIT_THRESH, thr);
            if (p == 1) hold_requests++;
            n = 0;
            while (n < PHASE_ITEMS) begin
                set_idling(done);
                if ($urandom_range(9) == 0) begin
                    // stray word of any kind
                    push_event(KIND_BITS'($urandom_range(3)), pick_recv(), 1'b0, '0);
                    n++;
                    done++;
                end else begin
                    // a run of acks closed by a loss event
                    run_len = $urandom_range(1, 48);
                    for (int j = 0; j < run_len; j++)
                        push_event(KIND_ACK, pick_recv(), 1'b0, '0);
                    push_event(($urandom_range(9) < 4) ? KIND_TIMEOUT : KIND_DUPACK,
                               pick_recv(), 1'b0, '0);
                    n += run_len + 1;
                    done += run_len + 1;
                end
            end
        end

        // wide limits, a timeout and a run of acks, then a low threshold to push acks into congestion avoidance
        set_idling(RANDOM_ITEMS);
        write_reg(REG_SEND_LIMIT, '1);
        write_reg(REG_INIT_THRESH, '1);
        push_event(KIND_TIMEOUT, '1, 1'b0, '0);
        for (int j = 0; j < TAIL_ACKS; j++)
            push_event(KIND_ACK, pick_recv(), 1'b0, '0);
        write_reg(REG_INIT_THRESH, 16'd10);
        for (int j = 0; j < 5; j++)
            push_event(KIND_ACK, '1, 1'b0, '0);
        push_event(KIND_DUPACK, '1, 1'b0, '0);
        push_event(KIND_ACK, '1, 1'b0, '0);
        push_event(KIND_TIMEOUT, '1, 1'b0, '0);
        i_s_axis_tvalid <= 1'b0;

        while (pending_windows.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d acks, %0d timeouts, %0d dup acks, %0d unused-kind words;",
                 kind_tally[KIND_ACK], kind_tally[KIND_TIMEOUT], kind_tally[KIND_DUPACK],
                 kind_tally[KIND_UNUSED]);
        $display("%0d result words checked, peak window %0d, six register settings plus a tail run.",
                 words_checked, peak_cwnd);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_dp.sv
design/tcp_congestion_window.sv
bench/tb.sv
